@@ rtl/min_witness_bool_convolution_defines.svh @@
// Assertion macros for the minimum-witness convolution block
`ifndef MIN_WITNESS_BOOL_CONVOLUTION_DEFINES_SVH
`define MIN_WITNESS_BOOL_CONVOLUTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MWBC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mwbc check failed");

// Consequent must hold in the cycle after the antecedent
`define MWBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mwbc check failed");

`endif

@@ rtl/mwbc_pkg.sv @@
// Shared types and constants for the minimum-witness convolution block
package mwbc_pkg;

    // Store depths
    localparam int A_LEN   = 64;
    localparam int B_LEN   = 64;
    localparam int N_ITEMS = 64;

    // Field widths
    localparam int OP_W      = 3;
    localparam int IDX_W     = 7;
    localparam int VAL_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_SEL_W = 1;
    localparam int ITEM_W    = VAL_W;
    localparam int POS_W     = $clog2(N_ITEMS);
    localparam int A_IDX_W   = $clog2(A_LEN);
    localparam int B_IDX_W   = $clog2(B_LEN);

    // Register indexes and reset values
    localparam logic [CFG_SEL_W-1:0] CFG_ITEM_COUNT = 1'b0;
    localparam logic [CFG_SEL_W-1:0] CFG_B_LENGTH   = 1'b1;
    localparam logic [CFG_W-1:0]     ITEM_COUNT_RST = 7'd64;
    localparam logic [CFG_W-1:0]     B_LENGTH_RST   = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A     = 3'd0,
        OP_LOAD_B     = 3'd1,
        OP_LOAD_W     = 3'd2,
        OP_LOAD_ORDER = 3'd3,
        OP_QUERY      = 3'd4
    } mwbc_op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } mwbc_state_e;

    // Load beat as seen by the stores
    typedef struct packed {
        logic                 en;
        mwbc_op_e             op;
        logic [IDX_W-1:0]     index;
        logic [VAL_W-1:0]     value;
    } mwbc_load_t;

    // Scan control from the sequencer to the evaluator
    typedef struct packed {
        logic                 clear;
        logic                 rd_valid;
        logic [ITEM_W-1:0]    rd_item;
        logic [POS_W-1:0]     rd_pos;
    } mwbc_scan_t;

    // Per-cell control
    typedef struct packed {
        logic                 load;
        logic                 shift;
    } mwbc_cell_ctl_t;

endpackage

@@ rtl/min_witness_bool_convolution.sv @@
// Top level: beat handling, order-cell ring, scan sequencer and result register
//
// Channel  Direction  Beat
// s_       in         tuser = operation, tdata = index, value
// m_       out        tuser = found, tdata = position
// cfg_     in         register write, no read-back
//
// s_tready stays high after a load, so loads can follow back to back.
// A query rotates the order ring once, one position per cycle, in the scan
// state, then passes the drain state and the hold state, which fills the
// result register, before s_tready returns.
// A result held on a stalled m_ side does not block loads; a following
// query waits in its last cycle until the result register is free.
// aresetn is synchronous; a/b vectors clear, weights and order are undefined.

`include "min_witness_bool_convolution_defines.svh"

module min_witness_bool_convolution
    import mwbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [6:0] index, [12:7] value
    input  logic [OP_W-1:0]       s_tuser,   // [2:0] operation

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [5:0] position
    output logic                  m_tuser,   // [0] found

    input  logic                  cfg_wr_en,
    input  logic [CFG_SEL_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    mwbc_state_e        state_reg, state_next;
    logic [POS_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   query_idx_reg;
    logic [CFG_W-1:0]   item_count_reg;
    logic [CFG_W-1:0]   b_length_reg;
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [POS_W-1:0]   m_position_reg;

    logic               s_accept;
    logic               q_accept;
    logic               shift;
    logic               out_free;
    logic               out_load;
    logic [CFG_W-1:0]   n_sat;
    logic [CFG_W-1:0]   blen_sat;
    mwbc_op_e           op;
    mwbc_load_t         ld;
    mwbc_scan_t         sc;
    logic               ev_found;
    logic [POS_W-1:0]   ev_position;
    logic [ITEM_W-1:0]  cell_q [N_ITEMS];

    assign op       = mwbc_op_e'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign q_accept = s_accept && (op == OP_QUERY);
    assign out_free = !m_valid_reg || m_tready;

    // Saturated register values
    assign n_sat    = (item_count_reg > CFG_W'(N_ITEMS)) ? CFG_W'(N_ITEMS) : item_count_reg;
    assign blen_sat = (b_length_reg > CFG_W'(B_LEN)) ? CFG_W'(B_LEN) : b_length_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= ITEM_COUNT_RST;
            b_length_reg   <= B_LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ITEM_COUNT: item_count_reg <= cfg_wdata;
                CFG_B_LENGTH:   b_length_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_accept) state_next = ST_SCAN;
            ST_SCAN:  if (scan_cnt_reg == POS_W'(N_ITEMS - 1)) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_HOLD;
            ST_HOLD:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready = 1'b0;
        shift    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  shift    = 1'b1;
            ST_DRAIN: ;
            ST_HOLD:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan position and query index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
        end else if (q_accept) begin
            scan_cnt_reg <= '0;
        end else if (shift) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_accept) begin
            query_idx_reg <= s_tdata[IDX_W-1:0];
        end
    end

    // Load beat to the stores
    assign ld.en    = s_accept;
    assign ld.op    = op;
    assign ld.index = s_tdata[IDX_W-1:0];
    assign ld.value = s_tdata[IDX_W +: VAL_W];

    // Order ring: cell 0 is the head, each cell takes from the next one up
    for (genvar i = 0; i < N_ITEMS; i++) begin : g_cell
        mwbc_cell_ctl_t ctl;

        assign ctl.load  = s_accept && (op == OP_LOAD_ORDER)
                           && (ld.index < IDX_W'(N_ITEMS))
                           && (ld.index[POS_W-1:0] == POS_W'(i));
        assign ctl.shift = shift;

        mwbc_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .load_data (ld.value),
            .shift_in  (cell_q[(i + 1) % N_ITEMS]),
            .item      (cell_q[i])
        );
    end

    // Scan control for the evaluator
    assign sc.clear    = q_accept;
    assign sc.rd_valid = shift && ({1'b0, scan_cnt_reg} < n_sat);
    assign sc.rd_item  = cell_q[0];
    assign sc.rd_pos   = scan_cnt_reg;

    mwbc_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld        (ld),
        .sc        (sc),
        .query_idx (query_idx_reg),
        .blen      (blen_sat),
        .found     (ev_found),
        .position  (ev_position)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg    <= ev_found;
            m_position_reg <= ev_position;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {(8 - POS_W)'(0), m_position_reg};

    // Checks
    `MWBC_ASSERT_NEXT(a_query_start, aclk, aresetn, q_accept, (state_reg == ST_SCAN) && (scan_cnt_reg == '0))
    `MWBC_ASSERT_SAME(a_miss_pos_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `MWBC_ASSERT_NEXT(a_hold_to_out, aclk, aresetn, out_load, m_tvalid && (state_reg == ST_IDLE))

endmodule

@@ rtl/mwbc_cell.sv @@
// One order-list cell: holds the item id of one order position, shifts in a ring
module mwbc_cell
    import mwbc_pkg::*;
(
    input  logic               aclk,
    input  mwbc_cell_ctl_t     ctl,
    input  logic [ITEM_W-1:0]  load_data,
    input  logic [ITEM_W-1:0]  shift_in,
    output logic [ITEM_W-1:0]  item
);

    logic [ITEM_W-1:0] item_reg;

    // Direct load from a beat, else take the neighbour's entry while scanning
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            item_reg <= load_data;
        end else if (ctl.shift) begin
            item_reg <= shift_in;
        end
    end

    assign item = item_reg;

endmodule

@@ rtl/mwbc_eval.sv @@
// Weight memory, a/b bit vectors and the first-witness tracker
module mwbc_eval
    import mwbc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  mwbc_load_t         ld,
    input  mwbc_scan_t         sc,
    input  logic [IDX_W-1:0]   query_idx,
    input  logic [CFG_W-1:0]   blen,
    output logic               found,
    output logic [POS_W-1:0]   position
);

    logic [VAL_W-1:0]  weight_mem [N_ITEMS];
    logic [A_LEN-1:0]  a_bits_reg;
    logic [B_LEN-1:0]  b_bits_reg;
    logic [VAL_W-1:0]  rd_weight_reg;
    logic [POS_W-1:0]  tag_pos_reg;
    logic              tag_valid_reg;
    logic              found_reg;
    logic [POS_W-1:0]  position_reg;

    logic              a_hit;
    logic              r_ge_w;
    logic [IDX_W-1:0]  j;
    logic              j_in_b;
    logic              b_hit;
    logic              hit;

    // Weight memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ld.en && (ld.op == OP_LOAD_W) && (ld.index < IDX_W'(N_ITEMS))) begin
            weight_mem[ld.index[POS_W-1:0]] <= ld.value;
        end
        rd_weight_reg <= weight_mem[sc.rd_item];
        tag_pos_reg   <= sc.rd_pos;
    end

    // Bit vectors, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_bits_reg <= '0;
            b_bits_reg <= '0;
        end else if (ld.en) begin
            if ((ld.op == OP_LOAD_A) && (ld.index < IDX_W'(A_LEN))) begin
                a_bits_reg[ld.index[A_IDX_W-1:0]] <= ld.value[0];
            end
            if ((ld.op == OP_LOAD_B) && (ld.index < IDX_W'(B_LEN))) begin
                b_bits_reg[ld.index[B_IDX_W-1:0]] <= ld.value[0];
            end
        end
    end

    // Witness test on the weight read last cycle
    always_comb begin
        a_hit  = a_bits_reg[rd_weight_reg[A_IDX_W-1:0]];
        r_ge_w = query_idx >= IDX_W'(rd_weight_reg);
        j      = query_idx - IDX_W'(rd_weight_reg);
        j_in_b = j < blen;
        b_hit  = b_bits_reg[j[B_IDX_W-1:0]];
        hit    = tag_valid_reg && a_hit && r_ge_w && j_in_b && b_hit;
    end

    // Keep the first qualifying position of the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            tag_valid_reg <= sc.rd_valid;
            if (sc.clear) begin
                found_reg <= 1'b0;
            end else if (hit && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sc.clear) begin
            position_reg <= '0;
        end else if (hit && !found_reg) begin
            position_reg <= tag_pos_reg;
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

endmodule
